// ===== rtl/core/bfmdh_pkg.sv =====
// Package: shared constants and a rotate helper for the Bloom filter block.
package bfmdh_pkg;
    localparam logic [31:0] C1 = 32'hcc9e2d51;
    localparam logic [31:0] C2 = 32'h1b873593;
    localparam logic [31:0] C3 = 32'he6546b64;
    localparam logic [31:0] F1 = 32'h85ebca6b;
    localparam logic [31:0] F2 = 32'hc2b2ae35;
    localparam logic [31:0] KEY_TOTAL_MAX = 32'hffffffff;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_BITS_IN_USE = 1'b0;
    localparam logic REG_PROBE_COUNT = 1'b1;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
        logic [63:0] d;
        d = {x, x} << r;
        return d[63:32];
    endfunction
endpackage

// ===== rtl/core/bfmdh_ram.sv =====
// Generic single-port write, single read-port RAM with registered read.
module bfmdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/core/bloom_filter_murmur3_double_hash.sv =====
// Bloom filter top level: key words are buffered in a RAM as they arrive (one per cycle
// while collecting; s_tready is low while a key is processed). On the last word the key is
// hashed twice from the buffer; each full word goes through read, two multiply steps and mix,
// a trailing partial word through a tail multiply, the second multiply step and mix, and then
// the finalization runs. Each probe position is then reduced by a bit-serial modulo unit and
// tested or set by read-modify-write of the filter RAM; a query stops at its first clear bit.
// After reset a clearing pass writes zeros over the filter RAM, one byte a cycle; no
// transaction is accepted during it. A new key is not accepted until the previous result has
// been issued, which waits for any earlier result to be taken.
module bloom_filter_murmur3_double_hash #(
    parameter int FILTER_BITS   = 65536,
    parameter int MAX_KEY_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // key_word
    input  logic [3:0]  s_tuser,   // cmd, word_bytes[2:0]
    input  logic        s_tlast,   // last_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // key_too_long, keys_added[31:0], zero fill
    output logic        m_tuser,   // may_contain
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    import bfmdh_pkg::*;

    localparam int STORE_BYTES = (FILTER_BITS + 7) / 8;
    localparam int SAW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int KW = (MAX_KEY_BYTES + 3) / 4;
    localparam int KAW = (KW > 1) ? $clog2(KW) : 1;
    localparam int LW = $clog2(MAX_KEY_BYTES + 4) + 1;
    localparam int MW = $clog2(FILTER_BITS) + 1;
    localparam logic [MW-1:0] M_MAX = MW'(FILTER_BITS);

    typedef enum logic [3:0] {
        S_CLEAR, S_COLLECT, S_HRD, S_HMUL1, S_HMUL2, S_HMIX, S_FIN1, S_FIN2, S_FIN3,
        S_MOD, S_FRD, S_FWAIT, S_FWR, S_OUT
    } state_t;

    state_t state_reg;
    logic [16:0] bits_reg;
    logic [7:0] probes_reg;
    logic [LW-1:0] len_reg;
    logic ovf_reg;
    logic [31:0] total_reg;
    logic [1:0] fill_reg;
    logic [31:0] part_reg;
    logic cmd_reg;
    logic pass_reg;
    logic [KAW:0] widx_reg;
    logic [31:0] h_reg, h1_reg, h2_reg, k_reg, pos_reg, rem_reg;
    logic [MW-1:0] m_reg;
    logic [5:0] bit_reg;
    logic [7:0] pidx_reg;
    logic hit_reg;
    logic [SAW-1:0] clr_reg;
    logic [SAW-1:0] faddr_reg;

    // key buffer
    logic kb_we;
    logic [KAW-1:0] kb_waddr, kb_raddr;
    logic [31:0] kb_wdata, kb_rdata;
    bfmdh_ram #(.WIDTH(32), .DEPTH(1 << KAW)) u_kbuf (
        .clk(clk), .we(kb_we), .waddr(kb_waddr), .wdata(kb_wdata),
        .raddr(kb_raddr), .rdata(kb_rdata));

    logic fs_we;
    logic [SAW-1:0] fs_waddr;
    logic [7:0] fs_wdata, fs_rdata;
    bfmdh_ram #(.WIDTH(8), .DEPTH(1 << SAW)) u_fstore (
        .clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(faddr_reg), .rdata(fs_rdata));

    // word input packing
    logic [2:0] nb;
    logic [3:0] sum;
    logic [63:0] merged;
    logic in_acc;
    assign nb = (s_tuser[3:1] > 3'd4) ? 3'd4 : s_tuser[3:1];
    assign in_acc = s_tvalid && s_tready;
    assign sum = {2'b0, fill_reg} + {1'b0, nb};
    always_comb
    begin
        logic [63:0] w;
        w = {32'b0, s_tdata} & ~(64'hffffffffffffffff << {nb, 3'b0});
        merged = {32'b0, part_reg} | (w << {fill_reg, 3'b0});
    end
    logic fits;
    assign fits = ({1'b0, len_reg} + (LW+1)'(nb)) <= (LW+1)'(MAX_KEY_BYTES);
    assign kb_we = in_acc && !ovf_reg && fits && sum[2];
    assign kb_waddr = len_reg[KAW+1:2];
    assign kb_wdata = merged[31:0];
    assign s_tready = (state_reg == S_COLLECT);

    logic [KAW:0] nfull;
    assign nfull = len_reg[KAW+2:2];
    assign kb_raddr = widx_reg[KAW-1:0];

    logic [MW-1:0] mclip;
    assign mclip = (bits_reg < 17'd8) ? MW'(8) :
                   ({15'b0, bits_reg} > 32'(FILTER_BITS)) ? M_MAX : MW'(bits_reg);

    logic [32:0] rsh;
    assign rsh = {rem_reg, pos_reg[31]};

    logic [31:0] tailk;
    assign tailk = part_reg;

    logic [31:0] total_next;
    assign total_next = (!ovf_reg && cmd_reg == CMD_ADD && total_reg != KEY_TOTAL_MAX) ?
                        total_reg + 32'd1 : total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            bits_reg <= 17'd65536;
            probes_reg <= 8'd7;
            len_reg <= '0;
            ovf_reg <= 1'b0;
            total_reg <= '0;
            fill_reg <= '0;
            part_reg <= '0;
            m_tvalid <= 1'b0;
            clr_reg <= '0;
            faddr_reg <= '0;
            widx_reg <= '0;
            pidx_reg <= '0;
            bit_reg <= '0;
            hit_reg <= 1'b0;
            pass_reg <= 1'b0;
            cmd_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_BITS_IN_USE) bits_reg <= cfg_data;
                else probes_reg <= cfg_data[7:0];
            end
            if (m_tvalid && m_tready && state_reg != S_OUT) m_tvalid <= 1'b0;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == SAW'(STORE_BYTES - 1)) state_reg <= S_COLLECT;
                end
                S_COLLECT:
                begin
                    if (in_acc)
                    begin
                        if (!ovf_reg)
                        begin
                            if (!fits) ovf_reg <= 1'b1;
                            else
                            begin
                                len_reg <= len_reg + LW'(nb);
                                fill_reg <= sum[1:0];
                                part_reg <= sum[2] ? merged[63:32] : merged[31:0];
                            end
                        end
                        if (s_tlast)
                        begin
                            cmd_reg <= s_tuser[0];
                            if (ovf_reg || !fits)
                            begin
                                hit_reg <= 1'b0;
                                pass_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                pass_reg <= 1'b0;
                                h_reg <= '0;
                                widx_reg <= '0;
                                m_reg <= mclip;
                                state_reg <= S_HRD;
                            end
                        end
                    end
                end
                S_HRD:
                begin
                    if (widx_reg < nfull)
                    begin
                        state_reg <= S_HMUL1;
                    end
                    else if (len_reg[1:0] != 2'd0)
                    begin
                        k_reg <= tailk * C1;
                        widx_reg <= widx_reg + 1'b1;
                        state_reg <= S_HMUL2;
                    end
                    else state_reg <= S_FIN1;
                end
                S_HMUL1:
                begin
                    k_reg <= kb_rdata * C1;
                    widx_reg <= widx_reg + 1'b1;
                    state_reg <= S_HMUL2;
                end
                S_HMUL2:
                begin
                    k_reg <= rotl(k_reg, 5'd15) * C2;
                    state_reg <= S_HMIX;
                end
                S_HMIX:
                begin
                    if (widx_reg <= nfull)
                        h_reg <= rotl(h_reg ^ k_reg, 5'd13) * 32'd5 + C3;
                    else
                        h_reg <= h_reg ^ k_reg;
                    state_reg <= (widx_reg <= nfull) ? S_HRD : S_FIN1;
                end
                S_FIN1:
                begin
                    h_reg <= (h_reg ^ 32'(len_reg)) ^ ((h_reg ^ 32'(len_reg)) >> 16);
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    k_reg <= h_reg * F1;
                    state_reg <= S_FIN3;
                end
                S_FIN3:
                begin
                    if (!bit_reg[0])
                    begin
                        h_reg <= (k_reg ^ (k_reg >> 13)) * F2;
                        bit_reg <= 6'd1;
                    end
                    else
                    begin
                        bit_reg <= '0;
                        widx_reg <= '0;
                        if (!pass_reg)
                        begin
                            h1_reg <= h_reg ^ (h_reg >> 16);
                            h_reg <= h_reg ^ (h_reg >> 16);
                            pass_reg <= 1'b1;
                            state_reg <= S_HRD;
                        end
                        else
                        begin
                            h2_reg <= h_reg ^ (h_reg >> 16);
                            pos_reg <= h1_reg;
                            rem_reg <= '0;
                            pidx_reg <= '0;
                            hit_reg <= 1'b1;
                            state_reg <= (probes_reg == 8'd0) ? S_OUT : S_MOD;
                        end
                    end
                end
                S_MOD:
                begin
                    // restoring division, one quotient bit per cycle
                    if (rsh >= 33'(m_reg)) rem_reg <= 32'(rsh - 33'(m_reg));
                    else rem_reg <= rsh[31:0];
                    pos_reg <= {pos_reg[30:0], 1'b0};
                    if (bit_reg == 6'd31)
                    begin
                        bit_reg <= '0;
                        state_reg <= S_FRD;
                    end
                    else bit_reg <= bit_reg + 1'b1;
                end
                S_FRD:
                begin
                    faddr_reg <= SAW'(rem_reg >> 3);
                    state_reg <= S_FWAIT;
                end
                S_FWAIT: state_reg <= S_FWR;
                S_FWR:
                begin
                    if (cmd_reg == CMD_QUERY && !fs_rdata[rem_reg[2:0]])
                    begin
                        hit_reg <= 1'b0;
                        state_reg <= S_OUT;
                    end
                    else if (pidx_reg + 8'd1 == probes_reg) state_reg <= S_OUT;
                    else
                    begin
                        pidx_reg <= pidx_reg + 8'd1;
                        pos_reg <= h1_reg + (32'(pidx_reg) + 32'd1) * h2_reg;
                        rem_reg <= '0;
                        state_reg <= S_MOD;
                    end
                end
                S_OUT:
                begin
                    if (!m_tvalid || m_tready)
                    begin
                        m_tvalid <= 1'b1;
                        m_tdata <= {7'b0, total_next, ovf_reg};
                        m_tuser <= (cmd_reg == CMD_QUERY) && !ovf_reg && hit_reg;
                        total_reg <= total_next;
                        len_reg <= '0;
                        fill_reg <= '0;
                        part_reg <= '0;
                        ovf_reg <= 1'b0;
                        state_reg <= S_COLLECT;
                    end
                end
                default: state_reg <= S_COLLECT;
            endcase
        end
    end

    assign fs_we = (state_reg == S_CLEAR) || (state_reg == S_FWR && cmd_reg == CMD_ADD);
    assign fs_waddr = (state_reg == S_CLEAR) ? clr_reg : faddr_reg;
    assign fs_wdata = (state_reg == S_CLEAR) ? 8'd0 : (fs_rdata | (8'd1 << rem_reg[2:0]));

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_COLLECT) |-> !s_tready) else $error("accept while busy");
    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !m_tvalid) else $error("result during clear");
    a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg)) else $error("count decreased");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FRD) |-> (rem_reg < 32'(m_reg))) else $error("modulo out of range");
`endif
endmodule
